FILE: rtl/pfa_pkg.sv
// Shared types, widths, codes and the init-time frame classifier for the
// page-frame allocator. No dependencies.
package pfa_pkg;

  localparam int MAX_FRAMES_DEF = 8192;
  localparam int REF_WIDTH_DEF  = 16;

  localparam int CFG_W       = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int OP_W        = 3;
  localparam int FRAME_W     = 13;
  localparam int STATUS_W    = 2;
  localparam int REF_OUT_W   = 16;
  localparam int FREE_W      = 14;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IO_HOLE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END    = 3'd4;

  localparam logic [CFG_W-1:0] TOTAL_PAGES_RST   = 14'd8192;
  localparam logic [CFG_W-1:0] BASE_PAGES_RST    = 14'd160;
  localparam logic [CFG_W-1:0] IO_HOLE_START_RST = 14'd160;
  localparam logic [CFG_W-1:0] EXT_START_RST     = 14'd256;
  localparam logic [CFG_W-1:0] KERNEL_END_RST    = 14'd512;

  localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
  localparam logic [OP_W-1:0] OP_INCREF = 3'd3;
  localparam logic [OP_W-1:0] OP_DECREF = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_MEM  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_INIT = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] total_pages;
    logic [CFG_W-1:0] base_pages;
    logic [CFG_W-1:0] io_hole_start;
    logic [CFG_W-1:0] ext_start;
    logic [CFG_W-1:0] kernel_end;
  } cfg_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_INIT,
    FSM_EXEC
  } fsm_e;

  // frame reserved at init: frame 0, the I/O hole through ext start, kernel image
  function automatic logic frame_used(input logic [31:0] f, input cfg_t cfg);
    logic [31:0] base;
    logic [31:0] io;
    logic [31:0] ext;
    logic [31:0] kend;
    base = 32'(cfg.base_pages);
    io   = 32'(cfg.io_hole_start);
    ext  = 32'(cfg.ext_start);
    kend = 32'(cfg.kernel_end);
    return (f == 32'd0) || (((f > base) || (f >= io)) && (f <= ext)) ||
           ((f > ext) && (f < kend));
  endfunction

endpackage

FILE: rtl/pfa_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the free-frame stack and the reference-count table. No dependencies.
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/pfa_ctrl.sv
// Allocator sequencer: init walk, read-modify-write of stack and count RAMs,
// result register. Depends on pfa_pkg and pfa_ram.
module pfa_ctrl #(
  parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  parameter int REF_WIDTH  = pfa_pkg::REF_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfa_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pfa_pkg::OP_W-1:0]        in_op_i,
  input  logic [pfa_pkg::FRAME_W-1:0]     in_frame_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pfa_pkg::STATUS_W-1:0]    out_status_o,
  output logic [pfa_pkg::FRAME_W-1:0]     out_frame_o,
  output logic [pfa_pkg::REF_OUT_W-1:0]   out_ref_o,
  output logic [pfa_pkg::FREE_W-1:0]      out_free_o
);
  import pfa_pkg::*;

  localparam int FRAME_AW = $clog2(MAX_FRAMES);
  localparam int DEPTH_W  = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W    = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
  localparam logic [CMP_W-1:0]     MAX_C   = CMP_W'(MAX_FRAMES);
  localparam logic [DEPTH_W-1:0]   MAX_D   = DEPTH_W'(MAX_FRAMES);
  localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};
  localparam logic [REF_WIDTH-1:0] REF_ONE = REF_WIDTH'(1);

  fsm_e                  state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [FRAME_W-1:0]    f_q, f_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [CMP_W-1:0]      walk_q, walk_d;
  logic                  init_done_q, init_done_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [FRAME_W-1:0]    out_frame_q, out_frame_d;
  logic [REF_OUT_W-1:0]  out_ref_q, out_ref_d;
  logic [FREE_W-1:0]     out_free_q, out_free_d;

  logic                  ref_we, ref_re;
  logic [FRAME_AW-1:0]   ref_waddr, ref_raddr;
  logic [REF_WIDTH-1:0]  ref_wdata, ref_rdata;
  logic                  stk_we, stk_re;
  logic [FRAME_AW-1:0]   stk_waddr, stk_raddr;
  logic [FRAME_W-1:0]    stk_wdata, stk_rdata;

  logic [CMP_W-1:0]      total_c, n_frames, f_ext, s_ext, in_ext;
  logic [DEPTH_W-1:0]    depth_m1;
  logic                  accept, can_load, f_ok, s_ok, full, walk_used;
  logic [REF_WIDTH-1:0]  res_ref, c_inc, c_dec;
  logic [31:0]           ref32, dep32;

  pfa_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_FRAMES)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  pfa_ram #(.WIDTH(REF_WIDTH), .DEPTH(MAX_FRAMES)) u_refs (
    .clk_i  (clk_i),
    .we_i   (ref_we),
    .waddr_i(ref_waddr),
    .wdata_i(ref_wdata),
    .re_i   (ref_re),
    .raddr_i(ref_raddr),
    .rdata_o(ref_rdata)
  );

  assign total_c   = CMP_W'(cfg_i.total_pages);
  assign n_frames  = (total_c > MAX_C) ? MAX_C : total_c;
  assign f_ext     = CMP_W'(f_q);
  assign s_ext     = CMP_W'(stk_rdata);
  assign in_ext    = CMP_W'(in_frame_i);
  assign f_ok      = f_ext < n_frames;
  assign s_ok      = s_ext < MAX_C;
  assign full      = depth_q == MAX_D;
  assign depth_m1  = depth_q - DEPTH_W'(1);
  assign c_inc     = ref_rdata + REF_ONE;
  assign c_dec     = ref_rdata - REF_ONE;
  assign walk_used = frame_used(32'(walk_q), cfg_i);

  assign in_ready_o = state_q == FSM_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign can_load   = !out_valid_q || out_ready_i;

  // reads are issued only on accept; write-back lands before the next accept
  assign ref_re    = accept;
  assign ref_raddr = in_ext[FRAME_AW-1:0];
  assign stk_re    = accept;
  assign stk_raddr = depth_m1[FRAME_AW-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    f_d          = f_q;
    depth_d      = depth_q;
    walk_d       = walk_q;
    init_done_d  = init_done_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_frame_d  = out_frame_q;
    out_ref_d    = out_ref_q;
    out_free_d   = out_free_q;
    ref_we       = 1'b0;
    ref_waddr    = f_ext[FRAME_AW-1:0];
    ref_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = depth_q[FRAME_AW-1:0];
    stk_wdata    = f_q;
    res_ref      = f_ok ? ref_rdata : '0;
    ref32        = '0;
    dep32        = '0;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          op_d = in_op_i;
          f_d  = in_frame_i;
          if (in_op_i == OP_INIT) begin
            depth_d = '0;
            walk_d  = '0;
            state_d = FSM_INIT;
          end else begin
            state_d = FSM_EXEC;
          end
        end
      end

      FSM_INIT: begin
        if (walk_q < n_frames) begin
          ref_we    = 1'b1;
          ref_waddr = walk_q[FRAME_AW-1:0];
          ref_wdata = walk_used ? REF_ONE : '0;
          if (!walk_used) begin
            stk_we    = 1'b1;
            stk_wdata = walk_q[FRAME_W-1:0];
            depth_d   = depth_q + DEPTH_W'(1);
          end
          walk_d = walk_q + CMP_W'(1);
        end else begin
          init_done_d = 1'b1;
          state_d     = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        out_status_d = STAT_OK;
        out_frame_d  = f_q;
        if (op_q == OP_INIT) begin
          res_ref = (f_ok && frame_used(32'(f_q), cfg_i)) ? REF_ONE : '0;
        end else if (!init_done_q) begin
          out_status_d = STAT_NO_INIT;
        end else begin
          unique case (op_q)
            OP_ALLOC: begin
              if (depth_q == '0) begin
                out_status_d = STAT_NO_MEM;
              end else begin
                depth_d     = depth_m1;
                out_frame_d = stk_rdata;
                ref_waddr   = s_ext[FRAME_AW-1:0];
                ref_we      = s_ok;
                res_ref     = '0;
              end
            end
            OP_FREE: begin
              if (!f_ok) begin
                out_status_d = STAT_BAD;
              end else if (ref_rdata != '0 || full) begin
                out_status_d = STAT_BAD;
              end else begin
                stk_we  = 1'b1;
                depth_d = depth_q + DEPTH_W'(1);
              end
            end
            OP_INCREF: begin
              if (!f_ok || ref_rdata == REF_MAX) begin
                out_status_d = STAT_BAD;
              end else begin
                ref_we    = 1'b1;
                ref_wdata = c_inc;
                res_ref   = c_inc;
              end
            end
            OP_DECREF: begin
              if (!f_ok || ref_rdata == '0) begin
                out_status_d = STAT_BAD;
              end else if (ref_rdata == REF_ONE) begin
                if (full) begin
                  out_status_d = STAT_BAD;
                end else begin
                  ref_we  = 1'b1;
                  stk_we  = 1'b1;
                  depth_d = depth_q + DEPTH_W'(1);
                  res_ref = '0;
                end
              end else begin
                ref_we    = 1'b1;
                ref_wdata = c_dec;
                res_ref   = c_dec;
              end
            end
            default: begin
            end
          endcase
        end
        ref32      = 32'(res_ref);
        dep32      = 32'(depth_d);
        out_ref_d  = ref32[REF_OUT_W-1:0];
        out_free_d = dep32[FREE_W-1:0];
        if (can_load) begin
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end else begin
          // hold: no write-back and no state change until the result slot frees
          ref_we       = 1'b0;
          stk_we       = 1'b0;
          depth_d      = depth_q;
          out_status_d = out_status_q;
          out_frame_d  = out_frame_q;
          out_ref_d    = out_ref_q;
          out_free_d   = out_free_q;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      depth_q     <= '0;
      walk_q      <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      walk_q      <= walk_d;
      init_done_q <= init_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    f_q          <= f_d;
    out_status_q <= out_status_d;
    out_frame_q  <= out_frame_d;
    out_ref_q    <= out_ref_d;
    out_free_q   <= out_free_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_frame_o  = out_frame_q;
  assign out_ref_o    = out_ref_q;
  assign out_free_o   = out_free_q;

endmodule

FILE: rtl/page_frame_allocator_refcount_core.sv
// Page-frame allocator top level: configuration registers, stream packing.
// Depends on pfa_pkg and pfa_ctrl.
// Alloc, free, incref, decref: after an accepted word the exec state loads the result
// register once the result slot is free; one read and one write-back of the stack and
// count RAMs; no new word until then, one item in flight; while a result waits, the next
// item is held before its write-back. Init: total frames walked (up to MAX_FRAMES), one frame per cycle.
// Reset: registers return to defaults, stack empty, not initialized; RAMs keep
// contents and every op but init reports not initialized until the first init.
module page_frame_allocator_refcount_core #(
  parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
  parameter int REF_WIDTH  = pfa_pkg::REF_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfa_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [pfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // frame[12:0], zero pad
  input  logic [pfa_pkg::OP_W-1:0]          s_axis_tuser_i,  // op[2:0]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // frame_out[12:0], ref_count[28:13], free_count[42:29], zero pad
  output logic [pfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic [pfa_pkg::STATUS_W-1:0]      m_axis_tuser_o   // status[1:0]
);
  import pfa_pkg::*;

  localparam int FREE_LSB = FRAME_W + REF_OUT_W;
  localparam int PAD_W    = OUT_TDATA_W - FRAME_W - REF_OUT_W - FREE_W;

  cfg_t                 cfg_q, cfg_d;
  logic [FRAME_W-1:0]   res_frame;
  logic [REF_OUT_W-1:0] res_ref;
  logic [FREE_W-1:0]    res_free;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TOTAL_PAGES:   cfg_d.total_pages   = cfg_data_i;
        REG_BASE_PAGES:    cfg_d.base_pages    = cfg_data_i;
        REG_IO_HOLE_START: cfg_d.io_hole_start = cfg_data_i;
        REG_EXT_START:     cfg_d.ext_start     = cfg_data_i;
        REG_KERNEL_END:    cfg_d.kernel_end    = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_pages   <= TOTAL_PAGES_RST;
      cfg_q.base_pages    <= BASE_PAGES_RST;
      cfg_q.io_hole_start <= IO_HOLE_START_RST;
      cfg_q.ext_start     <= EXT_START_RST;
      cfg_q.kernel_end    <= KERNEL_END_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfa_ctrl #(
    .MAX_FRAMES(MAX_FRAMES),
    .REF_WIDTH (REF_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_frame_i  (s_axis_tdata_i[FRAME_W-1:0]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_status_o(m_axis_tuser_o),
    .out_frame_o (res_frame),
    .out_ref_o   (res_ref),
    .out_free_o  (res_free)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, res_free, res_ref, res_frame};

  // one item at a time: an accepted word closes the input for the next cycle
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while an item is in work");

  // a new result only follows a cycle of work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without an item in work");

  // no-memory answer only with an empty stack
  a_no_mem_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STAT_NO_MEM) |->
      m_axis_tdata_o[FREE_LSB +: FREE_W] == '0)
    else $error("no-memory status with frames on the stack");

  // a waiting result holds still until taken
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result changed while waiting");

endmodule
